### rtl/core/ipdsc_pkg.sv
// shared types, constants and helpers for the ipd frame to servo compare core
package ipdsc_pkg;

  // frame and payload limits
  localparam int unsigned FRAME_CNT_W  = 8;
  localparam logic [FRAME_CNT_W-1:0] FRAME_LIMIT = 8'd200;
  localparam int unsigned PAY_CNT_W    = 4;
  localparam logic [PAY_CNT_W-1:0] PAYLOAD_LIMIT = 4'd15;

  // parsed magnitude and signed value widths
  localparam int unsigned MAG_W        = 17;
  localparam int unsigned VAL_W        = 18;
  localparam logic [MAG_W-1:0] VALUE_CAP = 17'd99999;

  // compare path widths
  localparam int unsigned CMP_W        = 16;
  localparam int unsigned SUM_W        = 20;
  localparam int unsigned RECIP_W      = 20;
  localparam int unsigned RECIP_SHIFT  = 23;
  localparam int unsigned PROD_W       = SUM_W + RECIP_W;
  // floor(2^23 / 9): quotient estimate is at most one low for sums below 2^20
  localparam logic [RECIP_W-1:0] RECIP_NINE = 20'd932067;

  // characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // tag match progress
  localparam logic [2:0] TAG_FOUND = 3'd4;

  // number parser phases
  localparam logic [1:0] PH_BLANK = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned Q_PTR_W     = 2;
  localparam int unsigned Q_CNT_W     = 3;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_MIN  = 2'd1;
  localparam logic [1:0] REG_MAX  = 2'd2;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic             found;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [7:0] tag_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0: ch = CH_PLUS;
      2'd1: ch = CH_I;
      2'd2: ch = CH_P;
      default: ch = CH_D;
    endcase
    return ch;
  endfunction

endpackage

### rtl/core/ipdsc_front.sv
// byte framer and payload number parser
module ipdsc_front
  import ipdsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_take,
  input  logic [7:0]       rx_byte,
  output logic             push,
  output frame_rec_t       push_rec
);

  logic [FRAME_CNT_W-1:0] frame_cnt_r, frame_cnt_nxt;
  logic                   o_pend_r, o_pend_nxt;
  logic [2:0]             tag_r, tag_nxt;
  logic                   colon_r, colon_nxt;
  logic [PAY_CNT_W-1:0]   pay_cnt_r, pay_cnt_nxt;
  logic [1:0]             phase_r, phase_nxt;
  logic                   neg_r, neg_nxt;
  logic [MAG_W-1:0]       mag_r, mag_nxt;

  logic                   is_digit;
  logic                   is_blank;
  logic [SUM_W-1:0]       acc_x10;
  logic [SUM_W-1:0]       acc_new;
  logic [MAG_W-1:0]       acc_sat;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_blank = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));

  // acc * 10 + digit, saturated
  assign acc_x10 = {mag_r, 3'b000} + {2'b00, mag_r, 1'b0};
  assign acc_new = acc_x10 + {{(SUM_W-4){1'b0}}, rx_byte[3:0]};
  assign acc_sat = (acc_new > {{(SUM_W-MAG_W){1'b0}}, VALUE_CAP}) ? VALUE_CAP
                                                                   : acc_new[MAG_W-1:0];

  assign push = byte_take && o_pend_r && (rx_byte == CH_K);
  assign push_rec = '{neg: neg_r, mag: mag_r, found: colon_r};

  always_comb begin
    frame_cnt_nxt = frame_cnt_r;
    o_pend_nxt    = o_pend_r;
    tag_nxt       = tag_r;
    colon_nxt     = colon_r;
    pay_cnt_nxt   = pay_cnt_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    if (byte_take) begin
      if (o_pend_r) begin
        // terminator done or frame discarded: start afresh either way
        frame_cnt_nxt = '0;
        o_pend_nxt    = 1'b0;
        tag_nxt       = '0;
        colon_nxt     = 1'b0;
        pay_cnt_nxt   = '0;
        phase_nxt     = PH_BLANK;
        neg_nxt       = 1'b0;
        mag_nxt       = '0;
      end else if (rx_byte == CH_O) begin
        o_pend_nxt = 1'b1;
      end else begin
        if (tag_r != TAG_FOUND) begin
          if (rx_byte == tag_char(tag_r[1:0])) begin
            tag_nxt = tag_r + 3'd1;
          end else begin
            tag_nxt = (rx_byte == CH_PLUS) ? 3'd1 : 3'd0;
          end
        end else if (!colon_r) begin
          if (rx_byte == CH_COLON) begin
            colon_nxt = 1'b1;
          end
        end else if (pay_cnt_r < PAYLOAD_LIMIT) begin
          pay_cnt_nxt = pay_cnt_r + 1'b1;
          unique case (phase_r)
            PH_BLANK: begin
              priority if (is_blank) begin
                phase_nxt = PH_BLANK;
              end else if (rx_byte == CH_PLUS) begin
                phase_nxt = PH_SIGN;
              end else if (rx_byte == CH_MINUS) begin
                neg_nxt   = 1'b1;
                phase_nxt = PH_SIGN;
              end else if (is_digit) begin
                mag_nxt   = acc_sat;
                phase_nxt = PH_DIGIT;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            PH_SIGN, PH_DIGIT: begin
              if (is_digit) begin
                mag_nxt   = acc_sat;
                phase_nxt = PH_DIGIT;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
        frame_cnt_nxt = frame_cnt_r + 1'b1;
        // over-long frame is dropped
        if (frame_cnt_nxt >= FRAME_LIMIT) begin
          frame_cnt_nxt = '0;
          tag_nxt       = '0;
          colon_nxt     = 1'b0;
          pay_cnt_nxt   = '0;
          phase_nxt     = PH_BLANK;
          neg_nxt       = 1'b0;
          mag_nxt       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cnt_r <= '0;
      o_pend_r    <= 1'b0;
      tag_r       <= '0;
      colon_r     <= 1'b0;
      pay_cnt_r   <= '0;
      phase_r     <= PH_BLANK;
      neg_r       <= 1'b0;
      mag_r       <= '0;
    end else begin
      frame_cnt_r <= frame_cnt_nxt;
      o_pend_r    <= o_pend_nxt;
      tag_r       <= tag_nxt;
      colon_r     <= colon_nxt;
      pay_cnt_r   <= pay_cnt_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      mag_r       <= mag_nxt;
    end
  end

endmodule

### rtl/core/ipdsc_queue.sv
// short queue of completed frame records between front and back
module ipdsc_queue
  import ipdsc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  frame_rec_t    push_rec,
  input  logic          pop,
  output frame_rec_t    pop_rec,
  output queue_status_t status
);

  frame_rec_t         mem_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign status.full  = (cnt_r == Q_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign pop_rec      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/core/ipdsc_back.sv
// three-stage compare pipeline: sum, reciprocal multiply, correct and clamp
module ipdsc_back
  import ipdsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  queue_status_t           q_status,
  input  frame_rec_t              q_rec,
  output logic                    pop,
  input  logic [CMP_W-1:0]        cmp_base,
  input  logic [CMP_W-1:0]        cmp_min,
  input  logic [CMP_W-1:0]        cmp_max,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CMP_W-1:0]        out_compare_value,
  output logic signed [VAL_W-1:0] out_command_value,
  output logic                    out_payload_found
);

  logic adv;

  // stage 1
  logic                    s1_valid_r;
  logic                    s1_neg_r;
  logic [SUM_W-1:0]        s1_sum_r;
  logic signed [VAL_W-1:0] s1_val_r;
  logic                    s1_found_r;
  // stage 2
  logic                    s2_valid_r;
  logic                    s2_neg_r;
  logic [SUM_W-1:0]        s2_sum_r;
  logic [MAG_W-1:0]        s2_q0_r;
  logic signed [VAL_W-1:0] s2_val_r;
  logic                    s2_found_r;
  // output
  logic                    out_valid_r;
  logic [CMP_W-1:0]        cmp_r;
  logic signed [VAL_W-1:0] val_r;
  logic                    found_r;

  logic signed [VAL_W-1:0] value;
  logic [SUM_W-1:0]        base9;
  logic signed [SUM_W:0]   sum_full;
  logic [PROD_W-1:0]       prod;
  logic [SUM_W:0]          nine_q;
  logic [SUM_W:0]          rem;
  logic [MAG_W-1:0]        quot;
  logic [MAG_W-1:0]        clamp_lo;
  logic [MAG_W-1:0]        clamp_hi;

  assign adv = !(out_valid_r && out_stall);
  assign pop = adv && !q_status.empty;

  assign value    = q_rec.neg ? -$signed({1'b0, q_rec.mag}) : $signed({1'b0, q_rec.mag});
  assign base9    = {1'b0, cmp_base, 3'b000} + {4'b0000, cmp_base};
  assign sum_full = $signed({1'b0, base9}) + (SUM_W+1)'(value);

  assign prod = s1_sum_r * RECIP_NINE;

  assign nine_q   = {1'b0, s2_q0_r, 3'b000} + {4'b0000, s2_q0_r};
  assign rem      = {1'b0, s2_sum_r} - nine_q;
  assign quot     = (rem >= (SUM_W+1)'(9)) ? s2_q0_r + 1'b1 : s2_q0_r;
  // lower bound first, then upper bound wins
  assign clamp_lo = (s2_neg_r || (quot < {1'b0, cmp_min})) ? {1'b0, cmp_min} : quot;
  assign clamp_hi = (clamp_lo > {1'b0, cmp_max}) ? {1'b0, cmp_max} : clamp_lo;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg_r   <= sum_full[SUM_W];
      s1_sum_r   <= sum_full[SUM_W-1:0];
      s1_val_r   <= value;
      s1_found_r <= q_rec.found;
      s2_neg_r   <= s1_neg_r;
      s2_sum_r   <= s1_sum_r;
      s2_q0_r    <= prod[RECIP_SHIFT +: MAG_W];
      s2_val_r   <= s1_val_r;
      s2_found_r <= s1_found_r;
      cmp_r      <= clamp_hi[CMP_W-1:0];
      val_r      <= s2_val_r;
      found_r    <= s2_found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= !q_status.empty;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_compare_value = cmp_r;
  assign out_command_value = val_r;
  assign out_payload_found = found_r;

endmodule

### rtl/core/at_ipd_frame_to_servo_compare_core.sv
// top level of the ipd frame to servo compare core
//
//  port group  dir  protocol        payload
//  in_         in   valid / stall   in_rx_byte[7:0]
//  out_        out  valid / stall   out_compare_value[15:0], out_command_value[17:0],
//                                   out_payload_found
//  apb         in   psel / penable  paddr[3:0], pwdata[31:0], prdata[31:0]
//
// one byte is taken per cycle unless stalled; the front parser updates its frame state
// in the cycle the byte is accepted and pushes a frame record into a four-entry queue
// on "OK"; the back pipeline takes a record into its sum stage, then multiplies and
// corrects, one record per cycle unless stalled; a record pushed on the 'K' passes the
// queue and the sum, product and output registers; in_stall rises only while the queue
// is full; out_stall freezes the back pipeline; synchronous active-low reset clears all
// frame state, the queue and the pipeline, and loads base 175, min 176, max 193
module at_ipd_frame_to_servo_compare_core
  import ipdsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // byte input
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_rx_byte,
  // result output
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CMP_W-1:0]        out_compare_value,
  output logic signed [VAL_W-1:0] out_command_value,
  output logic                    out_payload_found,
  // register port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [CMP_W-1:0] base_r, min_r, max_r;
  logic             cfg_wr;
  logic             byte_take;
  logic             push;
  logic             pop;
  frame_rec_t       push_rec;
  frame_rec_t       pop_rec;
  queue_status_t    q_status;

  // register port: always ready, word index in paddr[3:2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 16'd175;
      min_r  <= 16'd176;
      max_r  <= 16'd193;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BASE: base_r <= pwdata[CMP_W-1:0];
        REG_MIN:  min_r  <= pwdata[CMP_W-1:0];
        REG_MAX:  max_r  <= pwdata[CMP_W-1:0];
        default: begin
          // unmapped word, write ignored
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BASE: prdata = {16'h0000, base_r};
      REG_MIN:  prdata = {16'h0000, min_r};
      REG_MAX:  prdata = {16'h0000, max_r};
      default:  prdata = '0;
    endcase
  end

  // a full queue holds off the byte stream so no frame is lost
  assign in_stall  = q_status.full;
  assign byte_take = in_valid && !in_stall;

  ipdsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_take(byte_take),
    .rx_byte  (in_rx_byte),
    .push     (push),
    .push_rec (push_rec)
  );

  ipdsc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_rec(push_rec),
    .pop     (pop),
    .pop_rec (pop_rec),
    .status  (q_status)
  );

  ipdsc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .q_rec            (pop_rec),
    .pop              (pop),
    .cmp_base         (base_r),
    .cmp_min          (min_r),
    .cmp_max          (max_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_compare_value(out_compare_value),
    .out_command_value(out_command_value),
    .out_payload_found(out_payload_found)
  );

  // the queue is never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_status.full))
    else $error("frame queue written while full");

  // no colon seen means nothing was parsed
  a_no_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_payload_found) |-> (out_command_value == '0))
    else $error("command value without payload");

  // parsed value stays inside the saturation range
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_command_value <= 18'sd99999) && (out_command_value >= -18'sd99999)))
    else $error("command value out of range");

  // a pop only happens when a record is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty frame queue");

endmodule
